FILE: hdl/wvenv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the wavetable voice envelope core.
// No dependencies; imported by the controller, datapath and top level.
package wvenv_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int ROUND_SHIFT = 6 + SAMPLE_BITS;
    localparam int DIV_STEPS   = 15;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_LOAD   = 2'd1;
    localparam logic [1:0] ACT_RENDER = 2'd2;

    localparam logic [2:0] REG_PHASE_STEP  = 3'd0;
    localparam logic [2:0] REG_ATTACK_LEN  = 3'd1;
    localparam logic [2:0] REG_HOLD_LEN    = 3'd2;
    localparam logic [2:0] REG_HOLD_FADE   = 3'd3;
    localparam logic [2:0] REG_SOURCE_LEN  = 3'd4;
    localparam logic [2:0] REG_SOURCE_FADE = 3'd5;
    localparam logic [2:0] REG_VOLUME      = 3'd6;
    localparam logic [2:0] REG_TABLE_SIZE  = 3'd7;

    localparam logic [1:0] TERM_ATTACK = 2'd0;
    localparam logic [1:0] TERM_HOLD   = 2'd1;
    localparam logic [1:0] TERM_SOURCE = 2'd2;

    localparam logic [15:0] Q_ONE = 16'h8000;

    localparam int IN_BYTES  = 8;
    localparam int OUT_BYTES = 6;

    typedef struct packed {
        logic       accept;
        logic       kill;
        logic       amp_init;
        logic       div_load;
        logic       div_step;
        logic       amp_mul;
        logic       prod1;
        logic       prod2;
        logic       advance;
        logic       out_load;
        logic [1:0] term;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       note_active;
        logic       ended;
        logic       term_en;
        logic       out_free;
    } sts_t;

endpackage

FILE: hdl/wvenv_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the voice core: walks a render of an active note through check,
// envelope division, scaling and output, other requests to output. Depends on wvenv_pkg.
module wvenv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  wvenv_pkg::sts_t      sts,
    output wvenv_pkg::cmd_t      cmd
);
    import wvenv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_TERM, S_DIV, S_MUL, S_PROD1, S_PROD2, S_ADV, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic [3:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.act == ACT_RENDER && sts.note_active)
                        state_next = S_CHECK;
                    else
                        state_next = S_OUT;
                end
            end
            S_CHECK: begin
                if (sts.ended) begin
                    cmd.kill   = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.amp_init = 1'b1;
                    term_next    = TERM_ATTACK;
                    state_next   = S_TERM;
                end
            end
            S_TERM: begin
                if (sts.term_en) begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end else if (term_reg == TERM_SOURCE) begin
                    state_next = S_PROD1;
                end else begin
                    term_next = term_reg + 2'd1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DIV_STEPS - 1))
                    state_next = S_MUL;
            end
            S_MUL: begin
                cmd.amp_mul = 1'b1;
                if (term_reg == TERM_SOURCE) begin
                    state_next = S_PROD1;
                end else begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_TERM;
                end
            end
            S_PROD1: begin
                cmd.prod1  = 1'b1;
                state_next = S_PROD2;
            end
            S_PROD2: begin
                cmd.prod2  = 1'b1;
                state_next = S_ADV;
            end
            S_ADV: begin
                cmd.advance = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            term_reg  <= TERM_ATTACK;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/wvenv_dp.sv
`timescale 1ns / 1ps
// Datapath for the voice core: registers, wave table, divider, multipliers
// and output register. Depends on wvenv_pkg; driven by wvenv_ctrl.
module wvenv_dp #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [8*wvenv_pkg::IN_BYTES-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [8*wvenv_pkg::OUT_BYTES-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_index,
    input  logic [23:0]                      cfg_wdata,
    input  wvenv_pkg::cmd_t                  cmd,
    output wvenv_pkg::sts_t                  sts
);
    import wvenv_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = (AW > 16) ? AW : 16;

    logic [20:0] step_reg;
    logic [23:0] att_reg, hold_reg, hf_reg, src_reg, sf_reg;
    logic [15:0] vol_reg;
    logic [16:0] tsize_reg;

    logic [31:0] phase_reg;
    logic [23:0] elapsed_reg;
    logic        active_reg;

    logic signed [15:0] mem [TABLE_DEPTH];
    logic signed [15:0] rd_reg;
    logic               rd_ok_reg;

    logic [1:0]         in_act;
    logic [15:0]        in_addr;
    logic signed [15:0] in_word;
    logic signed [23:0] in_mix;

    logic signed [23:0] mix_res_reg;
    logic [15:0]        gain_res_reg;
    logic [15:0]        amp_reg;
    logic [23:0]        rem_reg, den_reg;
    logic [14:0]        q_reg;
    logic               sat_reg;
    logic signed [31:0] p1_reg;
    logic signed [47:0] p2_reg;

    logic               m_valid_reg;
    logic signed [23:0] m_mix_reg;
    logic               m_act_reg;
    logic [15:0]        m_gain_reg;

    logic [IW-1:0] wr_idx, rd_idx;
    logic          wr_ok, rd_ok;
    logic [15:0]   ip;
    logic [24:0]   t_hf, t_sf;
    logic [23:0]   div_num, div_den;
    logic [24:0]   rem_sh;
    logic [15:0]   g;
    logic [31:0]   amp_prod;
    logic [15:0]   vol_eff;
    logic signed [47:0] rnd;
    logic signed [25:0] contrib, sum;
    logic [32:0]   np;
    logic [31:0]   phase_adv;

    assign in_act  = s_tdata[1:0];
    assign in_addr = s_tdata[17:2];
    assign in_word = s_tdata[33:18];
    assign in_mix  = s_tdata[57:34];

    assign ip     = phase_reg[31:16];
    assign wr_idx = IW'(in_addr);
    assign rd_idx = IW'(ip);
    assign wr_ok  = 32'(in_addr) < 32'(TABLE_DEPTH);
    assign rd_ok  = 32'(ip) < 32'(TABLE_DEPTH);

    assign t_hf = {1'b0, elapsed_reg} + {1'b0, hf_reg};
    assign t_sf = {1'b0, elapsed_reg} + {1'b0, sf_reg};

    always_comb begin
        sts.act         = in_act;
        sts.note_active = active_reg;
        sts.ended       = (hold_reg != '0 && elapsed_reg >= hold_reg)
                        || (elapsed_reg > src_reg)
                        || (src_reg != '0 && elapsed_reg >= src_reg)
                        || ({1'b0, ip} >= tsize_reg);
        sts.out_free    = !m_valid_reg || m_tready;
        div_num         = elapsed_reg;
        div_den         = att_reg;
        sts.term_en     = 1'b0;
        case (cmd.term)
            TERM_ATTACK: begin
                sts.term_en = att_reg != '0 && elapsed_reg < att_reg;
            end
            TERM_HOLD: begin
                sts.term_en = hold_reg != '0 && hf_reg != '0 && t_hf > {1'b0, hold_reg};
                div_num     = hold_reg - elapsed_reg;
                div_den     = hf_reg;
            end
            TERM_SOURCE: begin
                sts.term_en = src_reg != '0 && sf_reg != '0 && t_sf > {1'b0, src_reg};
                div_num     = src_reg - elapsed_reg;
                div_den     = sf_reg;
            end
            default: sts.term_en = 1'b0;
        endcase
    end

    assign rem_sh    = {rem_reg, 1'b0};
    assign g         = sat_reg ? Q_ONE : {1'b0, q_reg};
    assign amp_prod  = 32'(amp_reg) * 32'(g);
    assign vol_eff   = (vol_reg > Q_ONE) ? Q_ONE : vol_reg;
    assign rnd       = p2_reg + (48'sd1 <<< (ROUND_SHIFT - 1));
    assign contrib   = 26'(rnd >>> ROUND_SHIFT);
    assign sum       = 26'(mix_res_reg) + contrib;
    assign np        = {1'b0, phase_reg} + 33'(step_reg);
    assign phase_adv = np[32] ? 32'hFFFF_FFFF : np[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.accept && in_act == ACT_LOAD && wr_ok)
            mem[wr_idx[AW-1:0]] <= in_word;
        rd_reg    <= mem[rd_idx[AW-1:0]];
        rd_ok_reg <= rd_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 21'd65536;
            att_reg     <= 24'd0;
            hold_reg    <= 24'd44100;
            hf_reg      <= 24'd4410;
            src_reg     <= 24'd176400;
            sf_reg      <= 24'd17640;
            vol_reg     <= 16'd32768;
            tsize_reg   <= 17'd0;
            phase_reg   <= '0;
            elapsed_reg <= '0;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PHASE_STEP:  step_reg  <= cfg_wdata[20:0];
                    REG_ATTACK_LEN:  att_reg   <= cfg_wdata;
                    REG_HOLD_LEN:    hold_reg  <= cfg_wdata;
                    REG_HOLD_FADE:   hf_reg    <= cfg_wdata;
                    REG_SOURCE_LEN:  src_reg   <= cfg_wdata;
                    REG_SOURCE_FADE: sf_reg    <= cfg_wdata;
                    REG_VOLUME:      vol_reg   <= cfg_wdata[15:0];
                    REG_TABLE_SIZE:  tsize_reg <= cfg_wdata[16:0];
                    default: ;
                endcase
            end
            if (cmd.accept && in_act == ACT_START) begin
                phase_reg   <= '0;
                elapsed_reg <= '0;
                active_reg  <= 1'b1;
            end
            if (cmd.kill)
                active_reg <= 1'b0;
            if (cmd.advance) begin
                phase_reg  <= phase_adv;
                if (elapsed_reg != 24'hFF_FFFF)
                    elapsed_reg <= elapsed_reg + 24'd1;
                active_reg <= {1'b0, phase_adv[31:16]} < tsize_reg;
            end
            if (cmd.out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mix_res_reg  <= in_mix;
            gain_res_reg <= '0;
        end
        if (cmd.amp_init)
            amp_reg <= Q_ONE;
        if (cmd.div_load) begin
            rem_reg <= div_num;
            den_reg <= div_den;
            sat_reg <= div_num >= div_den;
            q_reg   <= '0;
        end
        if (cmd.div_step) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_reg <= 24'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[13:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[23:0];
                q_reg   <= {q_reg[13:0], 1'b0};
            end
        end
        if (cmd.amp_mul)
            amp_reg <= amp_prod[30:15];
        if (cmd.prod1)
            p1_reg <= 32'((rd_ok_reg ? rd_reg : 16'sd0) * $signed({1'b0, vol_eff}));
        if (cmd.prod2)
            p2_reg <= 48'(p1_reg * $signed({1'b0, amp_reg}));
        if (cmd.advance) begin
            gain_res_reg <= amp_reg;
            if (sum > 26'sd8388607)
                mix_res_reg <= 24'sh7F_FFFF;
            else if (sum < -26'sd8388608)
                mix_res_reg <= 24'sh80_0000;
            else
                mix_res_reg <= sum[23:0];
        end
        if (cmd.out_load) begin
            m_mix_reg  <= mix_res_reg;
            m_gain_reg <= gain_res_reg;
            m_act_reg  <= (cmd.advance) ? 1'b0 : active_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_gain_reg, m_act_reg, m_mix_reg};

endmodule

FILE: hdl/wavetable_voice_envelope_core.sv
`timescale 1ns / 1ps
// Top level of the wavetable voice with envelope: sequencer plus datapath.
// Depends on wvenv_pkg, wvenv_ctrl and wvenv_dp.
//
//  Channel  Dir  Bus                          Contents
//  s_       in   tvalid/tready/tdata[63:0]    action, table_addr, table_word, mix_in
//  m_       out  tvalid/tready/tdata[47:0]    mix_out, voice_active, env_gain
//  cfg_     in   we/index[2:0]/wdata[23:0]    eight setup registers
//
// Start and load requests pass from idle straight to the output state and the
// output register. A render walks check, the three envelope terms (each active
// term using the 15-step shared restoring divider and one multiply), two products,
// advance and output; a render that ends the note goes from check to output.
// One request is in flight; a new one is taken while the last result waits.
// Reset is synchronous, active low; the wave table is not cleared.
module wavetable_voice_envelope_core #(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // action[1:0], table_addr[17:2], table_word[33:18], mix_in[57:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // mix_out[23:0], voice_active[24], env_gain[40:25]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);
    import wvenv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wvenv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wvenv_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: hdl/wvenv_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the voice core, bound to the top level.
// Depends on wavetable_voice_envelope_core.
module wvenv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[40:25] <= 16'h8000)
        else $error("gain above unity");

    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind wavetable_voice_envelope_core wvenv_checker u_wvenv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
